// File: src/kmer_read_vote_classifier_defines.svh
// Assertion macros for the k-mer read vote classifier.
`ifndef KMER_READ_VOTE_CLASSIFIER_DEFINES_SVH
`define KMER_READ_VOTE_CLASSIFIER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define KRVC_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define KRVC_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KRVC_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons, msg)
`define KRVC_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons, msg)
`endif

`endif

// File: src/krvc_pkg.sv
// Types, codes and helpers of the k-mer read vote classifier.
package krvc_pkg;

	// Result verdict codes
	typedef enum logic [1:0] {
		VERDICT_UNMAPPED  = 2'd0,
		VERDICT_UNIQUE    = 2'd1,
		VERDICT_AMBIGUOUS = 2'd2
	} verdict_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] CFG_COVERAGE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHARE_OF_TOTAL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVE_MODE = 2'd3;

	// Field widths
	localparam int GENOME_W = 6;
	localparam int KMERS_W = 16;
	localparam int HITS_W = 16;
	localparam int COVERAGE_W = 17;
	localparam int RATIO_W = 16;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd256;

	// Clamp a count to the 16-bit result field
	function automatic logic [HITS_W-1:0] sat16(logic [31:0] v);
		logic [HITS_W-1:0] r;
		r = (v > 32'd65535) ? 16'hFFFF : v[HITS_W-1:0];
		return r;
	endfunction

endpackage

// File: src/kmer_read_vote_classifier.sv
// Top level of the k-mer read vote classifier: per-genome hit counts and read verdicts.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | hit_genome, hit_present, read_end, read_kmers
//  out     | out_valid / out_stall| verdict, match_genome, match_hits, run_end
//  cfg     | cfg_we               | cfg_index, cfg_data
//
//  Hit items enter one per cycle while in_stall is low; the count memory does
//  read-modify-write with forwarding between back-to-back hits on the same genome.
//  The read's last item starts a scan of the count memory: a drain step, a find pass
//  over all genomes for the dominant one, the coverage test (multiply, decide), then
//  per-genome read, multiply, test to list and clear, a last result; intake is stalled.
//  out_stall holds the listing until the output register frees up.
//  After reset a clearing pass over all genomes zeroes the memory before intake opens.
module kmer_read_vote_classifier #(
	parameter int GENOMES = 64,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [krvc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [krvc_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input items
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [krvc_pkg::GENOME_W-1:0]        hit_genome,
	input  logic                                 hit_present,
	input  logic                                 read_end,
	input  logic [krvc_pkg::KMERS_W-1:0]         read_kmers,
	// result items
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           verdict,
	output logic [krvc_pkg::GENOME_W-1:0]        match_genome,
	output logic [krvc_pkg::HITS_W-1:0]          match_hits,
	output logic                                 run_end
);

`include "kmer_read_vote_classifier_defines.svh"

	localparam int AW = $clog2(GENOMES);
	localparam int CW = COUNT_WIDTH;
	localparam int DNW = (CW > krvc_pkg::KMERS_W) ? CW : krvc_pkg::KMERS_W;
	localparam int CPW = krvc_pkg::COVERAGE_W + DNW;
	localparam int RPW = krvc_pkg::RATIO_W + CW;
	localparam logic [AW-1:0] LAST_ID = AW'(GENOMES - 1);
	localparam logic [CW-1:0] CNT_MAX = '1;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_DRAIN,
		ST_FIND,
		ST_FIND_END,
		ST_COV,
		ST_DEC,
		ST_RD,
		ST_MUL,
		ST_TEST,
		ST_LAST
	} state_t;

	state_t state_q;

	// configuration registers
	logic [krvc_pkg::COVERAGE_W-1:0] cov_q;
	logic [krvc_pkg::RATIO_W-1:0]    ratio_q;
	logic                            share_q;
	logic                            sens_q;

	// count memory
	logic [CW-1:0] mem [GENOMES];
	logic [CW-1:0] rd_q;
	logic [AW-1:0] mem_ra;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [CW-1:0] mem_wd;

	// hit update pipeline
	logic          s1_v;
	logic [AW-1:0] s1_addr;
	logic          s2_v;
	logic [AW-1:0] s2_addr;
	logic [CW-1:0] s2_cnt;
	logic [CW-1:0] upd_cur;
	logic [CW-1:0] upd_nxt;

	// scan state
	logic [AW-1:0]  ptr_q;
	logic           f_v_s1;
	logic [AW-1:0]  f_addr_s1;
	logic [CW-1:0]  best_q;
	logic [AW-1:0]  best_id_q;
	logic [CW-1:0]  hit_total_q;
	logic [krvc_pkg::KMERS_W-1:0] kmers_q;
	logic [CPW-1:0] cov_prod_q;
	logic [CW-1:0]  cnt_q;
	logic [RPW-1:0] rat_prod_q;
	logic           unm_q;
	logic           amb_q;
	logic [AW-1:0]  pend_id_q;
	logic [CW-1:0]  pend_cnt_q;

	// output register
	logic                          out_valid_q;
	krvc_pkg::verdict_t            verdict_q;
	logic [krvc_pkg::GENOME_W-1:0] genome_q;
	logic [krvc_pkg::HITS_W-1:0]   hits_q;
	logic                          run_end_q;

	logic           in_acc;
	logic           hit_ok;
	logic           out_free;
	logic           out_load;
	logic [DNW-1:0] denom;
	logic           cov_lt;
	logic           unmapped;
	logic           list_match;

	// intake opens only between reads
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign hit_ok = hit_present && (32'(hit_genome) < GENOMES);
	assign out_free = !out_valid_q || !out_stall;

	// load the output register on a listed genome or the read's last result
	assign out_load = out_free && (((state_q == ST_TEST) && list_match) ||
		(state_q == ST_LAST));

	// forward the previous write when the same genome follows
	assign upd_cur = (s2_v && (s2_addr == s1_addr)) ? s2_cnt : rd_q;
	assign upd_nxt = (upd_cur == CNT_MAX) ? upd_cur : upd_cur + 1'b1;

	// read address: hit genome while counting, scan pointer otherwise
	always_comb begin
		mem_ra = ptr_q;
		if (state_q == ST_IDLE) begin
			mem_ra = AW'(hit_genome);
		end
	end

	// write: count update, reset clearing, or clear behind the listing
	assign mem_we = s1_v || (state_q == ST_CLR) || (state_q == ST_MUL);
	assign mem_wa = s1_v ? s1_addr : ptr_q;
	assign mem_wd = s1_v ? upd_nxt : '0;

	// decision arithmetic
	assign denom = share_q ? DNW'(kmers_q) : DNW'(hit_total_q);
	assign cov_lt = CPW'({best_q, 16'h0000}) < cov_prod_q;
	assign unmapped = (best_q == '0) || (!sens_q && cov_lt);
	assign list_match = !unm_q && (cnt_q != '0) && (ptr_q != best_id_q) &&
		(sens_q || (RPW'({best_q, 8'h00}) < rat_prod_q));

	// count memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	// hit update pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s1_addr <= '0;
			s2_v <= 1'b0;
			s2_addr <= '0;
			s2_cnt <= '0;
		end else begin
			s1_v <= in_acc && hit_ok;
			s1_addr <= AW'(hit_genome);
			s2_v <= s1_v;
			s2_addr <= s1_addr;
			s2_cnt <= upd_nxt;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cov_q <= '0;
			ratio_q <= krvc_pkg::RATIO_RESET;
			share_q <= 1'b0;
			sens_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				krvc_pkg::CFG_COVERAGE_LIMIT: cov_q <= cfg_data;
				krvc_pkg::CFG_RATIO_LIMIT: ratio_q <= cfg_data[krvc_pkg::RATIO_W-1:0];
				krvc_pkg::CFG_SHARE_OF_TOTAL: share_q <= cfg_data[0];
				krvc_pkg::CFG_SENSITIVE_MODE: sens_q <= cfg_data[0];
			endcase
		end
	end

	// sequencer, scan registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			ptr_q <= '0;
			f_v_s1 <= 1'b0;
			f_addr_s1 <= '0;
			best_q <= '0;
			best_id_q <= '0;
			hit_total_q <= '0;
			kmers_q <= '0;
			cov_prod_q <= '0;
			cnt_q <= '0;
			rat_prod_q <= '0;
			unm_q <= 1'b0;
			amb_q <= 1'b0;
			pend_id_q <= '0;
			pend_cnt_q <= '0;
			out_valid_q <= 1'b0;
			verdict_q <= krvc_pkg::VERDICT_UNMAPPED;
			genome_q <= '0;
			hits_q <= '0;
			run_end_q <= 1'b0;
		end else begin
			// raise valid on a new result, drop it once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			// track the dominant genome behind the find reads
			f_v_s1 <= (state_q == ST_FIND);
			f_addr_s1 <= ptr_q;
			if (f_v_s1 && (rd_q > best_q)) begin
				best_q <= rd_q;
				best_id_q <= f_addr_s1;
			end

			unique case (state_q)
				ST_CLR: begin
					if (ptr_q == LAST_ID) begin
						ptr_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_acc && hit_ok && (hit_total_q != CNT_MAX)) begin
						hit_total_q <= hit_total_q + 1'b1;
					end
					if (in_acc && read_end) begin
						kmers_q <= read_kmers;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					best_q <= '0;
					best_id_q <= '0;
					ptr_q <= '0;
					state_q <= ST_FIND;
				end
				ST_FIND: begin
					if (ptr_q == LAST_ID) begin
						state_q <= ST_FIND_END;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_FIND_END: begin
					state_q <= ST_COV;
				end
				ST_COV: begin
					cov_prod_q <= CPW'(cov_q) * CPW'(denom);
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					unm_q <= unmapped;
					amb_q <= 1'b0;
					pend_id_q <= unmapped ? '0 : best_id_q;
					pend_cnt_q <= unmapped ? '0 : best_q;
					hit_total_q <= '0;
					ptr_q <= '0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= rd_q;
					rat_prod_q <= RPW'(ratio_q) * RPW'(rd_q);
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					if (!list_match || out_free) begin
						// emit the held result, keep this genome pending
						if (list_match) begin
							verdict_q <= krvc_pkg::VERDICT_AMBIGUOUS;
							genome_q <= krvc_pkg::GENOME_W'(pend_id_q);
							hits_q <= krvc_pkg::sat16(32'(pend_cnt_q));
							run_end_q <= 1'b0;
							pend_id_q <= ptr_q;
							pend_cnt_q <= cnt_q;
							amb_q <= 1'b1;
						end
						if (ptr_q == LAST_ID) begin
							state_q <= ST_LAST;
						end else begin
							ptr_q <= ptr_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_LAST: begin
					if (out_free) begin
						if (unm_q) begin
							verdict_q <= krvc_pkg::VERDICT_UNMAPPED;
						end else if (amb_q) begin
							verdict_q <= krvc_pkg::VERDICT_AMBIGUOUS;
						end else begin
							verdict_q <= krvc_pkg::VERDICT_UNIQUE;
						end
						genome_q <= krvc_pkg::GENOME_W'(pend_id_q);
						hits_q <= krvc_pkg::sat16(32'(pend_cnt_q));
						run_end_q <= 1'b1;
						ptr_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign verdict = verdict_q;
	assign match_genome = genome_q;
	assign match_hits = hits_q;
	assign run_end = run_end_q;

	// the read's last item starts the drain before the scan
	`KRVC_ASSERT_NXT(a_end_starts_drain, clk, arst_n, in_acc && read_end, state_q == ST_DRAIN, "end item did not start the scan")
	// an unmapped result is a single blank item
	`KRVC_ASSERT_NOW(a_unmapped_blank, clk, arst_n, out_valid && (verdict == krvc_pkg::VERDICT_UNMAPPED), (match_genome == '0) && (match_hits == '0) && run_end, "malformed unmapped result")
	// the find pass and decision never touch the count memory
	`KRVC_ASSERT_NOW(a_no_write_in_find, clk, arst_n, (state_q == ST_FIND) || (state_q == ST_FIND_END) || (state_q == ST_COV) || (state_q == ST_DEC), !mem_we, "count memory written during the find pass")
	// the final step always hands out the read's last result
	`KRVC_ASSERT_NXT(a_last_gives_run_end, clk, arst_n, (state_q == ST_LAST) && out_free, out_valid && run_end, "last result missing run_end")

endmodule
